// ===== rtl/cfsq_pkg.sv =====
package cfsq_pkg;

	localparam int TYPE_W = 3;
	localparam int ID_W   = 29;
	localparam int LEN_W  = 4;
	localparam int PAY_W  = 64;
	localparam int CFG_W  = 3;
	localparam int CFG_IDX_W = 1;
	localparam int BYTES  = PAY_W / 8;

	localparam logic [CFG_IDX_W-1:0] REG_STD_DATA = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_DATA = 1'b1;

	localparam logic       CMD_PUSH = 1'b0;
	localparam logic       CMD_POP  = 1'b1;
	localparam logic       ST_OK    = 1'b0;
	localparam logic       ST_FAIL  = 1'b1;
	localparam logic [TYPE_W-1:0] TYPE_NONE = '0;
	localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(BYTES);

	typedef struct packed {
		logic [TYPE_W-1:0] kind;
		logic [ID_W-1:0]   ident;
		logic [LEN_W-1:0]  count;
		logic [PAY_W-1:0]  bytes;
	} slot_t;

	typedef struct packed {
		logic push;
		logic pop_rd;
		logic pop_miss;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pop_hit;
	} dp_status_t;

	typedef enum logic [2:0] {
		FSM_IDLE = 3'b001,
		FSM_RD   = 3'b010,
		FSM_OUT  = 3'b100
	} fsm_state_t;

endpackage

// ===== rtl/can_frame_slot_queue.sv =====
// Channel   Handshake                 Payload
// request   in_valid / in_stall       command, frame_kind, can_ident, byte_count, data_payload
// result    out_valid / out_stall     status, out_frame_kind, out_can_ident, out_byte_count,
//                                     out_data_payload
// config    cfg_we                    cfg_index, cfg_data
//
// A push and a pop of an empty slot go from idle to the output state; a pop hit passes through the
// read state first, for the registered read port of the slot memory. The output state holds while out_stall is high.
// One request is in flight at a time; in_stall is high until its result is taken.
// Reset clears the occupancy flags and both indexes and sets the type code registers to 1 and 2, at once.
module can_frame_slot_queue import cfsq_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [TYPE_W-1:0]    frame_kind,
	input  logic [ID_W-1:0]      can_ident,
	input  logic [LEN_W-1:0]     byte_count,
	input  logic [PAY_W-1:0]     data_payload,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 status,
	output logic [TYPE_W-1:0]    out_frame_kind,
	output logic [ID_W-1:0]      out_can_ident,
	output logic [LEN_W-1:0]     out_byte_count,
	output logic [PAY_W-1:0]     out_data_payload
);

	ctrl_cmd_t  cmd;
	dp_status_t dp_st;

	cfsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_st     (dp_st),
		.cmd       (cmd)
	);

	cfsq_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.dp_st            (dp_st),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.frame_kind       (frame_kind),
		.can_ident        (can_ident),
		.byte_count       (byte_count),
		.data_payload     (data_payload),
		.status           (status),
		.out_frame_kind   (out_frame_kind),
		.out_can_ident    (out_can_ident),
		.out_byte_count   (out_byte_count),
		.out_data_payload (out_data_payload)
	);

endmodule

// ===== rtl/cfsq_ram.sv =====
module cfsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/cfsq_ctrl.sv =====
module cfsq_ctrl import cfsq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       command,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t dp_st,
	output ctrl_cmd_t  cmd
);

	fsm_state_t state_q, state_d;
	logic       accept;

	assign accept    = in_valid && (state_q == FSM_IDLE);
	assign in_stall  = (state_q != FSM_IDLE);
	assign out_valid = (state_q == FSM_OUT);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					if (command == CMD_PUSH) begin
						cmd.push = 1'b1;
						state_d  = FSM_OUT;
					end else if (dp_st.pop_hit) begin
						cmd.pop_rd = 1'b1;
						state_d    = FSM_RD;
					end else begin
						cmd.pop_miss = 1'b1;
						state_d      = FSM_OUT;
					end
				end
			end
			FSM_RD: begin
				cmd.load = 1'b1;
				state_d  = FSM_OUT;
			end
			FSM_OUT: begin
				if (!out_stall) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/cfsq_dp.sv =====
module cfsq_dp import cfsq_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_cmd_t            cmd,
	output dp_status_t           dp_st,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [TYPE_W-1:0]    frame_kind,
	input  logic [ID_W-1:0]      can_ident,
	input  logic [LEN_W-1:0]     byte_count,
	input  logic [PAY_W-1:0]     data_payload,
	output logic                 status,
	output logic [TYPE_W-1:0]    out_frame_kind,
	output logic [ID_W-1:0]      out_can_ident,
	output logic [LEN_W-1:0]     out_byte_count,
	output logic [PAY_W-1:0]     out_data_payload
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	logic [TYPE_W-1:0] std_code_q, ext_code_q;
	logic [SLOTS-1:0]  occ_q;
	logic [IDX_W-1:0]  wr_idx_q, rd_idx_q;
	logic [IDX_W-1:0]  wr_idx_nxt, rd_idx_nxt;
	logic              push_is_data, pop_is_data, push_store;
	logic [LEN_W-1:0]  clen;
	logic [PAY_W-1:0]  masked;
	slot_t             wr_slot, rd_slot;

	assign dp_st.pop_hit = occ_q[rd_idx_q];
	assign wr_idx_nxt = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
	assign rd_idx_nxt = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;

	assign push_is_data = (frame_kind == std_code_q) || (frame_kind == ext_code_q);
	assign pop_is_data  = (rd_slot.kind == std_code_q) || (rd_slot.kind == ext_code_q);
	assign clen = (byte_count > LEN_MAX) ? LEN_MAX : byte_count;
	assign push_store = cmd.push && (frame_kind != TYPE_NONE) && !occ_q[wr_idx_q];

	always_comb begin
		for (int i = 0; i < BYTES; i++) begin
			masked[8*i +: 8] = (LEN_W'(i) < clen) ? data_payload[8*i +: 8] : 8'h00;
		end
	end

	always_comb begin
		wr_slot.kind  = frame_kind;
		wr_slot.ident = can_ident;
		wr_slot.count = push_is_data ? clen : '0;
		wr_slot.bytes = push_is_data ? masked : '0;
	end

	cfsq_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (push_store),
		.waddr (wr_idx_q),
		.wdata (wr_slot),
		.raddr (rd_idx_q),
		.rdata (rd_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			std_code_q <= TYPE_W'(1);
			ext_code_q <= TYPE_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STD_DATA: std_code_q <= cfg_data;
				REG_EXT_DATA: ext_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
		end else begin
			if (push_store) begin
				occ_q[wr_idx_q] <= 1'b1;
				wr_idx_q        <= wr_idx_nxt;
			end
			if (cmd.pop_rd) begin
				occ_q[rd_idx_q] <= 1'b0;
				rd_idx_q        <= rd_idx_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push || cmd.pop_miss) begin
			status           <= cmd.pop_miss ? ST_FAIL :
			                    ((frame_kind != TYPE_NONE) && occ_q[wr_idx_q]) ? ST_FAIL
			                                                                   : ST_OK;
			out_frame_kind   <= '0;
			out_can_ident    <= '0;
			out_byte_count   <= '0;
			out_data_payload <= '0;
		end else if (cmd.load) begin
			status           <= ST_OK;
			out_frame_kind   <= rd_slot.kind;
			out_can_ident    <= rd_slot.ident;
			out_byte_count   <= pop_is_data ? rd_slot.count : '0;
			out_data_payload <= pop_is_data ? rd_slot.bytes : '0;
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import cfsq_pkg::*;

	localparam int SLOTS = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 205;

	typedef struct packed {
		logic              cmd;
		logic [TYPE_W-1:0] kind;
		logic [ID_W-1:0]   ident;
		logic [LEN_W-1:0]  len;
		logic [PAY_W-1:0]  bytes;
	} frame_req_t;

	typedef struct packed {
		logic              st;
		logic [TYPE_W-1:0] kind;
		logic [ID_W-1:0]   ident;
		logic [LEN_W-1:0]  len;
		logic [PAY_W-1:0]  bytes;
	} frame_rsp_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 command = CMD_PUSH;
	logic [TYPE_W-1:0]    frame_kind = TYPE_NONE;
	logic [ID_W-1:0]      can_ident = '0;
	logic [LEN_W-1:0]     byte_count = '0;
	logic [PAY_W-1:0]     data_payload = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 status;
	logic [TYPE_W-1:0]    out_frame_kind;
	logic [ID_W-1:0]      out_can_ident;
	logic [LEN_W-1:0]     out_byte_count;
	logic [PAY_W-1:0]     out_data_payload;

	logic [TYPE_W-1:0] slot_kind  [SLOTS] = '{default: '0};
	logic [ID_W-1:0]   slot_ident [SLOTS] = '{default: '0};
	logic [LEN_W-1:0]  slot_count [SLOTS] = '{default: '0};
	logic [PAY_W-1:0]  slot_bytes [SLOTS] = '{default: '0};
	int                wr_ptr = 0;
	int                rd_ptr = 0;
	logic [CFG_W-1:0]  std_code = 3'd1;
	logic [CFG_W-1:0]  ext_code = 3'd2;

	frame_req_t  request_queue [$];
	frame_rsp_t  awaited_rsp [$];
	int          send_gap = 0;
	int          recv_wait = 0;
	logic        steady = 1'b0;
	int          errors = 0;
	int unsigned cycles = 0;

	can_frame_slot_queue #(.SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .frame_kind(frame_kind), .can_ident(can_ident),
		.byte_count(byte_count), .data_payload(data_payload),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .out_frame_kind(out_frame_kind), .out_can_ident(out_can_ident),
		.out_byte_count(out_byte_count), .out_data_payload(out_data_payload)
	);

	initial forever #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		$display("tb: mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [PAY_W-1:0] got, logic [PAY_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic logic carries_data(logic [TYPE_W-1:0] kind);
		return kind == std_code || kind == ext_code;
	endfunction

	function automatic frame_rsp_t ring_commit(frame_req_t req);
		frame_rsp_t       rsp;
		logic [LEN_W-1:0] len;
		logic [PAY_W-1:0] keep;
		rsp = '0;
		if (req.cmd == CMD_PUSH) begin
			if (req.kind == TYPE_NONE)
				return rsp;
			if (slot_kind[wr_ptr] != TYPE_NONE) begin
				rsp.st = ST_FAIL;
				return rsp;
			end
			slot_kind[wr_ptr] = req.kind;
			slot_ident[wr_ptr] = req.ident;
			slot_count[wr_ptr] = '0;
			slot_bytes[wr_ptr] = '0;
			if (carries_data(req.kind)) begin
				len = (req.len > LEN_MAX) ? LEN_MAX : req.len;
				keep = req.bytes;
				for (int b = 0; b < BYTES; b++)
					if (b >= len)
						keep[8*b +: 8] = '0;
				slot_count[wr_ptr] = len;
				slot_bytes[wr_ptr] = keep;
			end
			wr_ptr = (wr_ptr == SLOTS - 1) ? 0 : wr_ptr + 1;
			return rsp;
		end
		if (slot_kind[rd_ptr] == TYPE_NONE) begin
			rsp.st = ST_FAIL;
			return rsp;
		end
		rsp.kind = slot_kind[rd_ptr];
		rsp.ident = slot_ident[rd_ptr];
		if (carries_data(slot_kind[rd_ptr])) begin
			rsp.len = slot_count[rd_ptr];
			rsp.bytes = slot_bytes[rd_ptr];
		end
		slot_kind[rd_ptr] = TYPE_NONE;
		slot_ident[rd_ptr] = '0;
		slot_count[rd_ptr] = '0;
		slot_bytes[rd_ptr] = '0;
		rd_ptr = (rd_ptr == SLOTS - 1) ? 0 : rd_ptr + 1;
		return rsp;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_req_t next_req;
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= CMD_PUSH;
			frame_kind <= TYPE_NONE;
			can_ident <= '0;
			byte_count <= '0;
			data_payload <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				awaited_rsp.push_back(ring_commit(frame_req_t'{command, frame_kind,
					can_ident, byte_count, data_payload}));
			if (!(in_valid && in_stall)) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (request_queue.size() != 0) begin
					next_req = request_queue.pop_front();
					command <= next_req.cmd;
					frame_kind <= next_req.kind;
					can_ident <= next_req.ident;
					byte_count <= next_req.len;
					data_payload <= next_req.bytes;
					in_valid <= 1'b1;
					send_gap <= steady ? 0 : $urandom_range(0, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		frame_rsp_t want;
		int         w;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait <= 0;
		end else if (out_valid && !out_stall) begin
			if (awaited_rsp.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = awaited_rsp.pop_front();
				check_field("status", PAY_W'(status), PAY_W'(want.st));
				check_field("out_frame_kind", PAY_W'(out_frame_kind), PAY_W'(want.kind));
				check_field("out_can_ident", PAY_W'(out_can_ident), PAY_W'(want.ident));
				check_field("out_byte_count", PAY_W'(out_byte_count), PAY_W'(want.len));
				check_field("out_data_payload", out_data_payload, want.bytes);
			end
			w = steady ? 0 : $urandom_range(0, 3);
			recv_wait <= w;
			out_stall <= (w != 0);
		end else if (out_valid && out_stall) begin
			recv_wait <= recv_wait - 1;
			out_stall <= (recv_wait > 1);
		end
	end

	function automatic frame_req_t make_push(logic [TYPE_W-1:0] kind);
		frame_req_t r;
		r.cmd = CMD_PUSH;
		r.kind = kind;
		case ($urandom_range(0, 3))
			0: r.ident = '0;
			1: r.ident = '1;
			default: r.ident = ID_W'($urandom);
		endcase
		r.len = LEN_W'($urandom_range(0, 15));
		r.bytes = {$urandom, $urandom};
		return r;
	endfunction

	function automatic frame_req_t make_pop();
		frame_req_t r;
		r = make_push(TYPE_W'($urandom_range(0, 7)));
		r.cmd = CMD_POP;
		return r;
	endfunction

	function automatic logic [TYPE_W-1:0] pick_kind();
		case ($urandom_range(0, 9))
			0: return TYPE_NONE;
			1, 2, 3: return std_code;
			4, 5, 6: return ext_code;
			default: return TYPE_W'($urandom_range(1, 7));
		endcase
	endfunction

	function automatic frame_req_t shaped_push(logic [TYPE_W-1:0] kind, logic [ID_W-1:0] ident,
			logic [LEN_W-1:0] len, logic [PAY_W-1:0] bytes);
		return frame_req_t'{CMD_PUSH, kind, ident, len, bytes};
	endfunction

	task automatic wait_idle();
		do
			@(negedge clk);
		while (request_queue.size() != 0 || in_valid || awaited_rsp.size() != 0);
	endtask

	task automatic load_codes(logic [CFG_W-1:0] std_val, logic [CFG_W-1:0] ext_val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_STD_DATA;
		cfg_data <= std_val;
		@(posedge clk);
		cfg_index <= REG_EXT_DATA;
		cfg_data <= ext_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		std_code = std_val;
		ext_code = ext_val;
		@(negedge clk);
	endtask

	task automatic fill_phase(int n);
		int left;
		int burst;
		int mode;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 20);
			if (burst > left)
				burst = left;
			mode = $urandom_range(0, 2);
			repeat (burst) begin
				if (mode == 0 || (mode == 2 && $urandom_range(0, 1) == 1))
					request_queue.push_back(make_push(pick_kind()));
				else
					request_queue.push_back(make_pop());
			end
			left -= burst;
		end
	endtask

	initial begin
		logic [CFG_W-1:0] std_plan [8];
		logic [CFG_W-1:0] ext_plan [8];
		std_plan = '{3'd7, 3'd1, 3'd7, 3'd3, 3'd1, 3'd5, 3'd0, 3'd0};
		ext_plan = '{3'd7, 3'd7, 3'd1, 3'd3, 3'd2, 3'd6, 3'd0, 3'd0};
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(negedge clk);

		request_queue.push_back(make_pop());
		request_queue.push_back(shaped_push(TYPE_NONE, '1, 4'd8, '1));
		request_queue.push_back(shaped_push(3'd1, '1, 4'd15, '1));
		request_queue.push_back(shaped_push(3'd2, '0, 4'd0, '1));
		request_queue.push_back(shaped_push(3'd7, 29'h0aaa_5555, 4'd5, '1));
		request_queue.push_back(make_pop());
		request_queue.push_back(make_pop());
		request_queue.push_back(make_pop());
		request_queue.push_back(shaped_push(3'd1, 29'h155, 4'd8, {$urandom, $urandom}));
		request_queue.push_back(shaped_push(3'd2, 29'h1555_5555, 4'd3, '1));
		request_queue.push_back(shaped_push(3'd2, 29'h0, 4'd9, 64'h0123_4567_89ab_cdef));
		request_queue.push_back(make_pop());
		request_queue.push_back(shaped_push(3'd4, 29'h7ff, 4'd0, '0));

		for (int p = 0; p < 8; p++) begin
			wait_idle();
			if (p >= 6)
				load_codes(CFG_W'($urandom_range(1, 7)), CFG_W'($urandom_range(1, 7)));
			else
				load_codes(std_plan[p], ext_plan[p]);
			steady = (p % 3 == 2);
			fill_phase(PHASE_ITEMS);
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
